// ===== src/tsqs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the touch sample qualifier and scaler.
package tsqs_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int POS_BITS    = 12;
    localparam int PROD_BITS   = SAMPLE_BITS + POS_BITS;
    localparam int IDX_BITS    = 3;
    localparam int DIV_STAGES  = POS_BITS;
    // qualify, multiply, saturation check, then one stage per quotient bit
    localparam int LANE_LAT    = 3 + DIV_STAGES;

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    localparam logic [SAMPLE_BITS-1:0] RST_X_MIN     = 12'h133;
    localparam logic [SAMPLE_BITS-1:0] RST_X_MAX     = 12'hEDA;
    localparam logic [SAMPLE_BITS-1:0] RST_Y_MIN     = 12'h0D0;
    localparam logic [SAMPLE_BITS-1:0] RST_Y_MAX     = 12'hE2F;
    localparam logic [SAMPLE_BITS-1:0] RST_NOISE_LIM = 12'd10;
    localparam logic [POS_BITS-1:0]    RST_WIDTH     = 12'd240;
    localparam logic [POS_BITS-1:0]    RST_HEIGHT    = 12'd320;

    typedef enum logic [IDX_BITS-1:0] {
        CFG_X_MIN     = 3'd0,
        CFG_X_MAX     = 3'd1,
        CFG_Y_MIN     = 3'd2,
        CFG_Y_MAX     = 3'd3,
        CFG_NOISE_LIM = 3'd4,
        CFG_WIDTH     = 3'd5,
        CFG_HEIGHT    = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic                   pen_down;
        logic [SAMPLE_BITS-1:0] x_first;
        logic [SAMPLE_BITS-1:0] y_first;
        logic [SAMPLE_BITS-1:0] x_second;
        logic [SAMPLE_BITS-1:0] y_second;
    } t_touch_in;

    typedef struct packed {
        logic                touch_valid;
        logic [POS_BITS-1:0] screen_x;
        logic [POS_BITS-1:0] screen_y;
    } t_touch_out;

    // calibration of one axis
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] hi;
        logic [POS_BITS-1:0]    span;
    } t_axis_cfg;

    // what one lane hands to the merge stage
    typedef struct packed {
        logic                ok;
        logic [POS_BITS-1:0] pos;
    } t_lane_res;

    // state carried through the divider pipeline
    typedef struct packed {
        logic                   ok;
        logic                   sat;
        logic [SAMPLE_BITS-1:0] rem;
        logic [POS_BITS-1:0]    low;
        logic [POS_BITS-1:0]    q;
        logic [SAMPLE_BITS-1:0] den;
    } t_div_st;

endpackage

// ===== src/touch_sample_qualify_and_scale.sv =====
`timescale 1ns / 1ps
// Top level: configuration registers, X and Y lanes, and the merge stage.
//
// Touch sample qualifier and scaler. Raise start with a sample item on
// i_item; busy is never high, so an item transfers on every cycle that start
// is high, one per clock with no gaps required. Each item yields exactly one
// result: o_result is presented for a single cycle with o_result_strobe
// high. There is no backpressure on the result side, so the receiver must
// capture the result in that cycle. Each result passes through the per-axis
// pipeline: one stage to qualify and offset, one for the 12x12 multiply, one
// for the saturation check, twelve restoring-division stages (one quotient
// bit each), and the merge stage that updates the held position.
// X and Y run in two identical lanes; the merge marks the result valid only
// when both lanes qualify, otherwise it repeats the last valid position.
// Calibration registers are written through i_cfg_we / i_cfg_idx / i_cfg_data
// and must only change while no item is in flight.
module touch_sample_qualify_and_scale (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  tsqs_pkg::t_touch_in                i_item,
    output logic                               o_result_strobe,
    output tsqs_pkg::t_touch_out               o_result,
    input  logic                               i_cfg_we,
    input  logic [tsqs_pkg::IDX_BITS-1:0]      i_cfg_idx,
    input  logic [tsqs_pkg::SAMPLE_BITS-1:0]   i_cfg_data
);

    localparam int SB  = tsqs_pkg::SAMPLE_BITS;
    localparam int PB  = tsqs_pkg::POS_BITS;
    localparam int LAT = tsqs_pkg::LANE_LAT;

    // calibration registers
    logic [SB-1:0] r_x_min, r_x_max, r_y_min, r_y_max, r_noise_lim;
    logic [PB-1:0] r_width, r_height;

    // per-item valid tracking alongside the lanes
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] n_vld;
    logic           accept;

    // held position and result flags
    logic [PB-1:0] r_held_x, r_held_y;
    logic          r_out_valid;
    logic          r_strobe;
    logic          n_both;

    tsqs_pkg::t_axis_cfg cfg_x, cfg_y;
    tsqs_pkg::t_lane_res res_x, res_y;

    assign busy   = 1'b0;   // fully pipelined, always ready
    assign accept = start && !busy;

    // configuration write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min     <= tsqs_pkg::RST_X_MIN;
            r_x_max     <= tsqs_pkg::RST_X_MAX;
            r_y_min     <= tsqs_pkg::RST_Y_MIN;
            r_y_max     <= tsqs_pkg::RST_Y_MAX;
            r_noise_lim <= tsqs_pkg::RST_NOISE_LIM;
            r_width     <= tsqs_pkg::RST_WIDTH;
            r_height    <= tsqs_pkg::RST_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (tsqs_pkg::t_cfg_idx'(i_cfg_idx))
                tsqs_pkg::CFG_X_MIN:     r_x_min     <= i_cfg_data;
                tsqs_pkg::CFG_X_MAX:     r_x_max     <= i_cfg_data;
                tsqs_pkg::CFG_Y_MIN:     r_y_min     <= i_cfg_data;
                tsqs_pkg::CFG_Y_MAX:     r_y_max     <= i_cfg_data;
                tsqs_pkg::CFG_NOISE_LIM: r_noise_lim <= i_cfg_data;
                tsqs_pkg::CFG_WIDTH:     r_width     <= i_cfg_data;
                tsqs_pkg::CFG_HEIGHT:    r_height    <= i_cfg_data;
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    assign cfg_x.lo   = r_x_min;
    assign cfg_x.hi   = r_x_max;
    assign cfg_x.span = r_width;
    assign cfg_y.lo   = r_y_min;
    assign cfg_y.hi   = r_y_max;
    assign cfg_y.span = r_height;

    // pen-down gates both lanes; each lane checks its own noise and calibration
    tsqs_lane u_lane_x (
        .i_clk    (i_clk),
        .i_en     (i_item.pen_down),
        .i_first  (i_item.x_first),
        .i_second (i_item.x_second),
        .i_lim    (r_noise_lim),
        .i_cfg    (cfg_x),
        .o_res    (res_x)
    );

    tsqs_lane u_lane_y (
        .i_clk    (i_clk),
        .i_en     (i_item.pen_down),
        .i_first  (i_item.y_first),
        .i_second (i_item.y_second),
        .i_lim    (r_noise_lim),
        .i_cfg    (cfg_y),
        .o_res    (res_y)
    );

    // valid shift matches the lane latency
    assign n_vld = {r_vld[LAT-2:0], accept};

    // merge: new position only when both axes qualify
    assign n_both = r_vld[LAT-1] && res_x.ok && res_y.ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_held_x    <= '0;
            r_held_y    <= '0;
            r_out_valid <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_vld       <= n_vld;
            r_out_valid <= n_both;
            r_strobe    <= r_vld[LAT-1];
            if (n_both) begin
                r_held_x <= res_x.pos;
                r_held_y <= res_y.pos;
            end
        end
    end

    // result is the held position, so an invalid result repeats the last one
    assign o_result_strobe      = r_strobe;
    assign o_result.touch_valid = r_out_valid;
    assign o_result.screen_x    = r_held_x;
    assign o_result.screen_y    = r_held_y;

    // every accepted item produces a result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(LAT+1) o_result_strobe)
        else $error("result strobe missing after accepted item");

    // a valid flag never appears without its strobe
    a_valid_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.touch_valid |-> o_result_strobe)
        else $error("touch_valid without result strobe");

    // an invalid result leaves the held position untouched
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && !o_result.touch_valid)
            |-> ($stable(o_result.screen_x) && $stable(o_result.screen_y)))
        else $error("held position changed on invalid result");

    // the strobe never runs ahead of the item pipeline
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(r_vld[LAT-1]))
        else $error("result strobe without item in flight");

endmodule

// ===== src/tsqs_div_stage.sv =====
`timescale 1ns / 1ps
// One registered restoring-division step: produces one quotient bit.
module tsqs_div_stage (
    input  logic              i_clk,
    input  tsqs_pkg::t_div_st i_st,
    output tsqs_pkg::t_div_st o_st
);

    logic [tsqs_pkg::SAMPLE_BITS:0] trial;
    logic [tsqs_pkg::SAMPLE_BITS:0] diff;
    logic                           ge;
    tsqs_pkg::t_div_st              n_st;
    tsqs_pkg::t_div_st              r_st;

    always_comb begin
        trial = {i_st.rem, i_st.low[tsqs_pkg::POS_BITS-1]};
        diff  = trial - {1'b0, i_st.den};
        ge    = (trial >= {1'b0, i_st.den});
        n_st      = i_st;
        n_st.rem  = ge ? diff[tsqs_pkg::SAMPLE_BITS-1:0] : trial[tsqs_pkg::SAMPLE_BITS-1:0];
        n_st.low  = {i_st.low[tsqs_pkg::POS_BITS-2:0], 1'b0};
        n_st.q    = {i_st.q[tsqs_pkg::POS_BITS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        r_st <= n_st;
    end

    assign o_st = r_st;

endmodule

// ===== src/tsqs_lane.sv =====
`timescale 1ns / 1ps
// One axis lane: noise check, average, offset, multiply and pipelined divide.
module tsqs_lane (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [tsqs_pkg::SAMPLE_BITS-1:0] i_first,
    input  logic [tsqs_pkg::SAMPLE_BITS-1:0] i_second,
    input  logic [tsqs_pkg::SAMPLE_BITS-1:0] i_lim,
    input  tsqs_pkg::t_axis_cfg              i_cfg,
    output tsqs_pkg::t_lane_res              o_res
);

    localparam int SB = tsqs_pkg::SAMPLE_BITS;
    localparam int PB = tsqs_pkg::POS_BITS;
    localparam int WB = tsqs_pkg::PROD_BITS;

    logic [SB:0]   sum;
    logic [SB-1:0] avg;
    logic [SB-1:0] adiff;
    logic          n_a_ok;

    logic          r_a_ok;
    logic [SB-1:0] r_a_off;
    logic [SB-1:0] r_a_den;
    logic [PB-1:0] r_a_span;

    logic          r_b_ok;
    logic [WB-1:0] r_b_num;
    logic [SB-1:0] r_b_den;

    tsqs_pkg::t_div_st r_c_st;
    tsqs_pkg::t_div_st st [tsqs_pkg::DIV_STAGES+1];

    // stage A: qualify the pair and form the axis offset and span
    always_comb begin
        sum    = {1'b0, i_first} + {1'b0, i_second};
        avg    = sum[SB:1];
        adiff  = (i_first >= i_second) ? (i_first - i_second) : (i_second - i_first);
        n_a_ok = i_en && (adiff < i_lim) && (avg > i_cfg.lo) && (i_cfg.hi > i_cfg.lo);
    end

    always_ff @(posedge i_clk) begin
        r_a_ok   <= n_a_ok;
        r_a_off  <= avg - i_cfg.lo;
        r_a_den  <= i_cfg.hi - i_cfg.lo;
        r_a_span <= i_cfg.span;
    end

    // stage B: product span * offset
    always_ff @(posedge i_clk) begin
        r_b_ok  <= r_a_ok;
        r_b_num <= {{(WB-PB){1'b0}}, r_a_span} * {{(WB-SB){1'b0}}, r_a_off};
        r_b_den <= r_a_den;
    end

    // stage C: quotient overflows the output range iff upper half >= divisor
    always_ff @(posedge i_clk) begin
        r_c_st.ok  <= r_b_ok;
        r_c_st.sat <= (r_b_num[WB-1:PB] >= r_b_den);
        r_c_st.rem <= r_b_num[WB-1:PB];
        r_c_st.low <= r_b_num[PB-1:0];
        r_c_st.q   <= '0;
        r_c_st.den <= r_b_den;
    end

    assign st[0] = r_c_st;

    for (genvar k = 0; k < tsqs_pkg::DIV_STAGES; k++) begin : g_div
        tsqs_div_stage u_step (
            .i_clk (i_clk),
            .i_st  (st[k]),
            .o_st  (st[k+1])
        );
    end

    assign o_res.ok  = st[tsqs_pkg::DIV_STAGES].ok;
    assign o_res.pos = st[tsqs_pkg::DIV_STAGES].sat ? tsqs_pkg::POS_MAX
                                                    : st[tsqs_pkg::DIV_STAGES].q;

endmodule

// ===== tb/tb_touch_sample_qualify_and_scale.sv =====
`timescale 1ns / 1ps
// Testbench for the touch sample qualifier and scaler: directed and random checks.
//
// A local predictor tracks the calibration registers and the held screen
// position. The monitor runs on every rising edge. It mirrors register
// writes, predicts one position per accepted sample transfer, and compares
// each result strobe with the oldest pending prediction. Stimulus writes
// registers only when nothing is in flight. Sample transfers go out with
// random gaps on the start side. There is no result backpressure, so the
// receive side cannot stall.
module tb_touch_sample_qualify_and_scale;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int PIPE_WAIT   = tsqs_pkg::LANE_LAT + 4;
    localparam int MAX_REPORTS = 50;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             start = 1'b0;
    logic                             busy;
    tsqs_pkg::t_touch_in              i_item = '0;
    logic                             o_result_strobe;
    tsqs_pkg::t_touch_out             o_result;
    logic                             i_cfg_we = 1'b0;
    logic [tsqs_pkg::IDX_BITS-1:0]    i_cfg_idx = '0;
    logic [tsqs_pkg::SAMPLE_BITS-1:0] i_cfg_data = '0;

    // Predictor state: mirrored registers and the last valid position.
    logic [tsqs_pkg::SAMPLE_BITS-1:0] cfg_mirror [0:6];
    logic [tsqs_pkg::POS_BITS-1:0]    last_x;
    logic [tsqs_pkg::POS_BITS-1:0]    last_y;
    tsqs_pkg::t_touch_out             pending_positions [$];

    int idle_pct = 34;
    int cycle_count = 0;
    int transfers = 0;
    int results_seen = 0;
    int valid_seen = 0;
    int reg_writes = 0;
    int errors = 0;

    touch_sample_qualify_and_scale dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_item          (i_item),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One axis: valid only when the average is above min and the span is
    // not empty; the quotient saturates at full scale.
    function automatic bit map_axis(input int avg, input int lo, input int hi,
                                    input int span,
                                    output logic [tsqs_pkg::POS_BITS-1:0] pos);
        int unsigned q;
        pos = '0;
        if (avg <= lo || hi <= lo) return 1'b0;
        q = (span * (avg - lo)) / (hi - lo);
        pos = (q > tsqs_pkg::POS_MAX) ? tsqs_pkg::POS_MAX : q[tsqs_pkg::POS_BITS-1:0];
        return 1'b1;
    endfunction

    function automatic tsqs_pkg::t_touch_out predict_touch_position(
        input tsqs_pkg::t_touch_in s);
        tsqs_pkg::t_touch_out          r;
        int                            dx, dy, lim;
        logic [tsqs_pkg::POS_BITS-1:0] px, py;
        bit                            ok_x, ok_y;
        lim = cfg_mirror[tsqs_pkg::CFG_NOISE_LIM];
        dx = (s.x_first > s.x_second) ? s.x_first - s.x_second : s.x_second - s.x_first;
        dy = (s.y_first > s.y_second) ? s.y_first - s.y_second : s.y_second - s.y_first;
        r.touch_valid = 1'b0;
        if (s.pen_down && dx < lim && dy < lim) begin
            // truncating average of the two samples
            ok_x = map_axis((int'(s.x_first) + int'(s.x_second)) >> 1,
                            cfg_mirror[tsqs_pkg::CFG_X_MIN], cfg_mirror[tsqs_pkg::CFG_X_MAX],
                            cfg_mirror[tsqs_pkg::CFG_WIDTH], px);
            ok_y = map_axis((int'(s.y_first) + int'(s.y_second)) >> 1,
                            cfg_mirror[tsqs_pkg::CFG_Y_MIN], cfg_mirror[tsqs_pkg::CFG_Y_MAX],
                            cfg_mirror[tsqs_pkg::CFG_HEIGHT], py);
            if (ok_x && ok_y) begin
                r.touch_valid = 1'b1;
                last_x = px;
                last_y = py;
            end
        end
        r.screen_x = last_x;
        r.screen_y = last_y;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: register mirror, prediction on each transfer, result check.
    // Inputs and outputs are sampled at the edge, before the DUT's
    // nonblocking updates land, so event order within the step is moot.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        tsqs_pkg::t_touch_out want;
        if (!i_rst_n) begin
            cfg_mirror[tsqs_pkg::CFG_X_MIN]     = tsqs_pkg::RST_X_MIN;
            cfg_mirror[tsqs_pkg::CFG_X_MAX]     = tsqs_pkg::RST_X_MAX;
            cfg_mirror[tsqs_pkg::CFG_Y_MIN]     = tsqs_pkg::RST_Y_MIN;
            cfg_mirror[tsqs_pkg::CFG_Y_MAX]     = tsqs_pkg::RST_Y_MAX;
            cfg_mirror[tsqs_pkg::CFG_NOISE_LIM] = tsqs_pkg::RST_NOISE_LIM;
            cfg_mirror[tsqs_pkg::CFG_WIDTH]     = tsqs_pkg::RST_WIDTH;
            cfg_mirror[tsqs_pkg::CFG_HEIGHT]    = tsqs_pkg::RST_HEIGHT;
            last_x = '0;
            last_y = '0;
        end else begin
            if (i_cfg_we && i_cfg_idx <= tsqs_pkg::CFG_HEIGHT) begin
                cfg_mirror[i_cfg_idx] = i_cfg_data;
                reg_writes++;
            end
            // predict before checking, in case a result lands on its own edge
            if (start === 1'b1 && busy === 1'b0) begin
                pending_positions.push_back(predict_touch_position(i_item));
                transfers++;
            end
            if (o_result_strobe === 1'b1) begin
                results_seen++;
                if (o_result.touch_valid === 1'b1) valid_seen++;
                if (pending_positions.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: result with nothing pending: %h", $time, o_result);
                end else begin
                    want = pending_positions.pop_front();
                    if (o_result.touch_valid !== want.touch_valid) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: touch_valid expected %b actual %b",
                                     $time, want.touch_valid, o_result.touch_valid);
                    end
                    if (o_result.screen_x !== want.screen_x) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: screen_x expected %0d actual %0d",
                                     $time, want.screen_x, o_result.screen_x);
                    end
                    if (o_result.screen_y !== want.screen_y) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: screen_y expected %0d actual %0d",
                                     $time, want.screen_y, o_result.screen_y);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers. All are called at a rising edge and drive with <=.
    // ------------------------------------------------------------------

    // One sample transfer, after an optional random gap. start stays high
    // on return; the next call or wait_idle decides its next value.
    task automatic send_touch(input tsqs_pkg::t_touch_in s);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= s;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Stop sending, let every pending result arrive, then let the pipe settle.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_positions.size() != 0) @(posedge i_clk);
        repeat (PIPE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input tsqs_pkg::t_cfg_idx idx, input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[tsqs_pkg::SAMPLE_BITS-1:0];
        @(posedge i_clk);
    endtask

    // Writes all seven registers while the block is idle.
    task automatic load_calibration(input int x_lo, input int x_hi, input int y_lo,
                                    input int y_hi, input int noise, input int w,
                                    input int h);
        wait_idle();
        write_reg(tsqs_pkg::CFG_X_MIN, x_lo);
        write_reg(tsqs_pkg::CFG_X_MAX, x_hi);
        write_reg(tsqs_pkg::CFG_Y_MIN, y_lo);
        write_reg(tsqs_pkg::CFG_Y_MAX, y_hi);
        write_reg(tsqs_pkg::CFG_NOISE_LIM, noise);
        write_reg(tsqs_pkg::CFG_WIDTH, w);
        write_reg(tsqs_pkg::CFG_HEIGHT, h);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Sample generators
    // ------------------------------------------------------------------

    function automatic tsqs_pkg::t_touch_in make_touch(input bit pen, input int x1,
                                                       input int y1, input int x2,
                                                       input int y2);
        tsqs_pkg::t_touch_in s;
        s.pen_down = pen;
        s.x_first  = x1[tsqs_pkg::SAMPLE_BITS-1:0];
        s.y_first  = y1[tsqs_pkg::SAMPLE_BITS-1:0];
        s.x_second = x2[tsqs_pkg::SAMPLE_BITS-1:0];
        s.y_second = y2[tsqs_pkg::SAMPLE_BITS-1:0];
        return s;
    endfunction

    // Pair inside the noise limit, centered mostly in the calibrated window,
    // sometimes above it to hit saturation.
    function automatic void near_pair(input int lo, input int hi, input int lim,
                                      output int a, output int b);
        int base, d, far;
        if (lo < hi && $urandom_range(9) != 0) base = $urandom_range(hi, lo + 1);
        else if (lo < 4095) base = $urandom_range(4095, lo + 1);
        else base = $urandom_range(4095);
        d = (lim > 0) ? $urandom_range(lim - 1) : 0;
        far = base + d;
        if (far > 4095) far = base - d;
        if (far < 0) far = 0;
        if ($urandom_range(1)) begin
            a = base; b = far;
        end else begin
            a = far; b = base;
        end
    endfunction

    // Pair whose difference is at or above the noise limit.
    function automatic void noisy_pair(input int lim, output int a, output int b);
        int d, base;
        d = $urandom_range(4095, lim);
        base = $urandom_range(4095 - d);
        if ($urandom_range(1)) begin
            a = base; b = base + d;
        end else begin
            a = base + d; b = base;
        end
    endfunction

    function automatic tsqs_pkg::t_touch_in clean_touch();
        int x1, x2, y1, y2;
        near_pair(cfg_mirror[tsqs_pkg::CFG_X_MIN], cfg_mirror[tsqs_pkg::CFG_X_MAX],
                  cfg_mirror[tsqs_pkg::CFG_NOISE_LIM], x1, x2);
        near_pair(cfg_mirror[tsqs_pkg::CFG_Y_MIN], cfg_mirror[tsqs_pkg::CFG_Y_MAX],
                  cfg_mirror[tsqs_pkg::CFG_NOISE_LIM], y1, y2);
        return make_touch(1'b1, x1, y1, x2, y2);
    endfunction

    // Well-formed sample with exactly one kind of defect.
    function automatic tsqs_pkg::t_touch_in broken_touch();
        tsqs_pkg::t_touch_in s;
        int a, b, v;
        s = clean_touch();
        case ($urandom_range(4))
            0: s.pen_down = 1'b0;
            1: begin
                noisy_pair(cfg_mirror[tsqs_pkg::CFG_NOISE_LIM], a, b);
                s.x_first = a[11:0]; s.x_second = b[11:0];
            end
            2: begin
                noisy_pair(cfg_mirror[tsqs_pkg::CFG_NOISE_LIM], a, b);
                s.y_first = a[11:0]; s.y_second = b[11:0];
            end
            3: begin
                v = $urandom_range(cfg_mirror[tsqs_pkg::CFG_X_MIN]);
                s.x_first = v[11:0]; s.x_second = v[11:0];
            end
            default: begin
                v = $urandom_range(cfg_mirror[tsqs_pkg::CFG_Y_MIN]);
                s.y_first = v[11:0]; s.y_second = v[11:0];
            end
        endcase
        return s;
    endfunction

    function automatic tsqs_pkg::t_touch_in noise_touch();
        return make_touch(1'($urandom_range(1)), $urandom_range(4095), $urandom_range(4095),
                          $urandom_range(4095), $urandom_range(4095));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset calibration: pen up, noise limit edges, minimum edges, extremes.
    task automatic test_reset_calibration();
        send_touch(make_touch(1'b0, 2000, 1900, 2001, 1901));   // pen up, held zero
        send_touch(make_touch(1'b1, 2000, 1900, 2001, 1903));   // centered touch
        send_touch(make_touch(1'b1, 2010, 1900, 2000, 1900));   // x diff at limit
        send_touch(make_touch(1'b1, 1500, 1000, 1500, 1009));   // y diff just under
        send_touch(make_touch(1'b1, 307, 1000, 307, 1000));     // x average at min
        send_touch(make_touch(1'b1, 308, 1000, 309, 1000));     // truncated, just above min
        send_touch(make_touch(1'b1, 1500, 208, 1500, 208));     // y average at min
        send_touch(make_touch(1'b1, 4095, 4095, 4095, 4095));   // full scale, above max
        send_touch(make_touch(1'b1, 0, 0, 0, 0));               // zero samples
        send_touch(make_touch(1'b1, 3000, 500, 2991, 509));     // first above second
        send_touch(make_touch(1'b0, 4095, 4095, 4095, 4095));   // pen up at full scale
    endtask

    // A zero noise limit rejects even identical samples.
    task automatic test_zero_noise_limit();
        load_calibration(tsqs_pkg::RST_X_MIN, tsqs_pkg::RST_X_MAX,
                         tsqs_pkg::RST_Y_MIN, tsqs_pkg::RST_Y_MAX, 0,
                         tsqs_pkg::RST_WIDTH, tsqs_pkg::RST_HEIGHT);
        send_touch(make_touch(1'b1, 2000, 2000, 2000, 2000));
        send_touch(make_touch(1'b1, 4095, 0, 4095, 0));
    endtask

    // Empty spans, zero screen span and saturation.
    task automatic test_span_edges();
        load_calibration(1000, 1000, 208, 3631, 4095, 240, 320);  // x max equal to min
        send_touch(make_touch(1'b1, 2000, 2000, 2000, 2000));
        load_calibration(307, 3802, 2000, 1500, 4095, 240, 320);  // y max below min
        send_touch(make_touch(1'b1, 2000, 2500, 2000, 2500));
        load_calibration(307, 3802, 208, 3631, 4095, 0, 320);     // zero screen width
        send_touch(make_touch(1'b1, 2000, 2000, 2000, 2000));
        load_calibration(0, 1, 0, 1, 4095, 4095, 4095);           // everything saturates
        send_touch(make_touch(1'b1, 4095, 4095, 4095, 4095));
        send_touch(make_touch(1'b1, 0, 4094, 4094, 0));           // widest pair within limit
        send_touch(make_touch(1'b1, 0, 0, 4095, 4095));           // widest pair, rejected
    endtask

    // Mostly well-formed touches, then defects and raw noise; optional
    // mid-phase pause until every result is back.
    task automatic test_random_traffic(input int count, input bit pause_mid);
        int pick;
        for (int i = 0; i < count; i++) begin
            if (pause_mid && i == count / 2) wait_idle();
            pick = $urandom_range(99);
            if (pick < 70) send_touch(clean_touch());
            else if (pick < 85) send_touch(broken_touch());
            else send_touch(noise_touch());
        end
    endtask

    task automatic test_random_calibration(input int count, input bit pause_mid);
        load_calibration($urandom_range(1500), $urandom_range(4095, 2500),
                         $urandom_range(1500), $urandom_range(4095, 2500),
                         $urandom_range(80, 1), $urandom_range(4095, 1),
                         $urandom_range(4095, 1));
        test_random_traffic(count, pause_mid);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_calibration();
        test_zero_noise_limit();
        test_span_edges();

        load_calibration(tsqs_pkg::RST_X_MIN, tsqs_pkg::RST_X_MAX,
                         tsqs_pkg::RST_Y_MIN, tsqs_pkg::RST_Y_MAX,
                         tsqs_pkg::RST_NOISE_LIM, tsqs_pkg::RST_WIDTH,
                         tsqs_pkg::RST_HEIGHT);
        test_random_traffic(120, 1'b0);

        // back-to-back stretch, one transfer per clock
        idle_pct = 0;
        test_random_calibration(150, 1'b0);
        idle_pct = 34;

        load_calibration(0, 4095, 0, 4095, 4095, 4095, 4095);      // widest window
        test_random_traffic(80, 1'b0);
        load_calibration(4094, 4095, 4094, 4095, 1, 1, 1);         // narrowest window
        test_random_traffic(60, 1'b0);
        load_calibration(0, 1, 0, 1, 64, 4095, 4095);              // heavy saturation
        test_random_traffic(60, 1'b0);

        for (int p = 0; p < 4; p++) test_random_calibration(95, p == 1);

        wait_idle();
        if (pending_positions.size() != 0) begin
            errors += pending_positions.size();
            $display("%0t: %0d predicted results never arrived", $time,
                     pending_positions.size());
        end
        $display("Covered %0d sample transfers and %0d results (%0d valid positions)",
                 transfers, results_seen, valid_seen);
        $display("across %0d register writes; %0d errors", reg_writes, errors);
        if (errors == 0) begin
            $display("tb_touch_sample_qualify_and_scale OK");
        end else begin
            $display("tb_touch_sample_qualify_and_scale NOT OK");
        end
        $finish;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("tb_touch_sample_qualify_and_scale NOT OK");
        $finish;
    end

endmodule
